// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP       = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = CFG_W'(5);
    localparam logic [CFG_W-1:0] SETUP_RESET       = CFG_W'(1);

    // Raw command codes on the tick channel
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       nack_after_read;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } result_t;

endpackage

// ===== src/i2cm_ifs.sv =====
// Channel interfaces: tick requests, per-tick results and configuration writes.
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       nack_after_read;
    logic       sda_in;

    modport source (output valid, output cmd, output tx_byte, output nack_after_read,
                    output sda_in, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input nack_after_read,
                    input sda_in, output ready);
endinterface

interface i2cm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;

    modport source (output valid, output scl_level, output sda_release, output busy_res,
                    output done_res, output rx_byte, output ack_received, input ready);
    modport sink   (input valid, input scl_level, input sda_release, input busy_res,
                    input done_res, input rx_byte, input ack_received, output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/i2cm_front.sv =====
// Front end: takes tick requests and classifies the command code.
module i2cm_front (
    i2cm_tick_if.sink         tick,
    output i2cm_pkg::tick_item_t item,
    output logic              item_valid,
    input  logic              item_ready
);
    import i2cm_pkg::*;

    kind_t kind;

    // Unknown codes fold into no command
    always_comb
    begin
        case (tick.cmd)
            CMD_START: kind = KIND_START;
            CMD_STOP:  kind = KIND_STOP;
            CMD_WRITE: kind = KIND_WRITE;
            CMD_READ:  kind = KIND_READ;
            default:   kind = KIND_NONE;
        endcase
    end

    assign item.kind            = kind;
    assign item.tx_byte         = tick.tx_byte;
    assign item.nack_after_read = tick.nack_after_read;
    assign item.sda_in          = tick.sda_in;
    assign item_valid           = tick.valid;
    assign tick.ready           = item_ready;

endmodule

// ===== src/i2cm_queue.sv =====
// Short register queue between the front end and the bus engine.
module i2cm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2cm_pkg::tick_item_t push_item,
    input  logic                 push_valid,
    output logic                 push_ready,
    output i2cm_pkg::tick_item_t pop_item,
    output logic                 pop_valid,
    input  logic                 pop_ready
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    tick_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/i2cm_engine.sv =====
// Back end: bus phase sequencer, configuration registers and result register.
module i2cm_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    i2cm_cfg_if.sink             cfg,
    input  i2cm_pkg::tick_item_t item,
    input  logic                 item_valid,
    output logic                 item_ready,
    i2cm_result_if.source        result
);
    import i2cm_pkg::*;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_PRE  = 4'd1;
    localparam logic [3:0] PH_ST_HIGH = 4'd2;
    localparam logic [3:0] PH_ST_HOLD = 4'd3;
    localparam logic [3:0] PH_SP_PRE  = 4'd4;
    localparam logic [3:0] PH_SP_HIGH = 4'd5;
    localparam logic [3:0] PH_SP_REL  = 4'd6;
    localparam logic [3:0] PH_W_LOW   = 4'd7;
    localparam logic [3:0] PH_W_SET   = 4'd8;
    localparam logic [3:0] PH_W_HI    = 4'd9;
    localparam logic [3:0] PH_R_LOW   = 4'd10;
    localparam logic [3:0] PH_R_SET   = 4'd11;
    localparam logic [3:0] PH_R_HI    = 4'd12;

    typedef struct packed {
        logic [3:0] phase;
        logic       scl;
        logic       sda;
    } bus_t;

    function automatic logic is_setup(input logic [3:0] p);
        return (p == PH_ST_PRE) || (p == PH_SP_PRE) || (p == PH_W_SET) || (p == PH_R_SET);
    endfunction

    // Levels a phase shows on its first tick
    function automatic bus_t apply_phase(input bus_t cur, input logic [3:0] p,
                                         input logic [3:0] bi, input logic [7:0] sh,
                                         input logic np);
        bus_t b;
        b       = cur;
        b.phase = p;
        case (p)
            PH_ST_PRE:  begin b.scl = 1'b0; b.sda = 1'b1; end
            PH_ST_HIGH: begin b.scl = 1'b1; b.sda = 1'b1; end
            PH_ST_HOLD: b.sda = 1'b0;
            PH_SP_PRE:  begin b.scl = 1'b0; b.sda = 1'b0; end
            PH_SP_HIGH: b.scl = 1'b1;
            PH_SP_REL:  b.sda = 1'b1;
            PH_W_LOW:   b.scl = 1'b0;
            PH_W_SET:   b.sda = (bi < 4'd8) ? sh[7] : 1'b1;
            PH_W_HI:    b.scl = 1'b1;
            PH_R_LOW:   b.scl = 1'b0;
            PH_R_SET:   b.sda = (bi < 4'd8) ? 1'b1 : np;
            PH_R_HI:    b.scl = 1'b1;
            default:    ;
        endcase
        return b;
    endfunction

    logic [CFG_W-1:0]       half_cfg_reg, setup_cfg_reg;
    logic [3:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tc_reg, tc_next;
    logic [3:0]             bi_reg, bi_next;
    logic [7:0]             sh_reg, sh_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_reg, ack_next;
    logic                   np_reg, np_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   res_valid_reg;
    result_t                res_reg, res_next;

    logic [31:0]            half_w, setup_w;
    logic [COUNT_WIDTH-1:0] half_len, setup_len, dur;
    logic                   go, done;
    logic [3:0]             target;
    bus_t                   bus;
    logic                   step;

    assign cfg.ready  = 1'b1;
    assign item_ready = !res_valid_reg || result.ready;
    assign step       = item_valid && item_ready;

    // A zero half period behaves as one; durations saturate at the counter limit
    always_comb
    begin
        half_w  = (half_cfg_reg == '0) ? 32'd1 : 32'(half_cfg_reg);
        setup_w = 32'(setup_cfg_reg);
        if (half_w > CNT_MAX)
        begin
            half_w = CNT_MAX;
        end
        if (setup_w > CNT_MAX)
        begin
            setup_w = CNT_MAX;
        end
        half_len  = half_w[COUNT_WIDTH-1:0];
        setup_len = setup_w[COUNT_WIDTH-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        tc_next    = tc_reg;
        bi_next    = bi_reg;
        sh_next    = sh_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        np_next    = np_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        go         = 1'b0;
        target     = PH_IDLE;
        dur        = half_len;
        bus        = '0;

        if (phase_reg == PH_IDLE)
        begin
            case (item.kind)
                KIND_START:
                begin
                    go     = 1'b1;
                    target = PH_ST_PRE;
                end
                KIND_STOP:
                begin
                    go     = 1'b1;
                    target = PH_SP_PRE;
                end
                KIND_WRITE:
                begin
                    sh_next = item.tx_byte;
                    bi_next = '0;
                    go      = 1'b1;
                    target  = PH_W_LOW;
                end
                KIND_READ:
                begin
                    sh_next = '0;
                    bi_next = '0;
                    np_next = item.nack_after_read;
                    go      = 1'b1;
                    target  = PH_R_LOW;
                end
                default: ;
            endcase
        end
        else
        begin
            // SDA is sampled on the first tick of a high phase
            if (tc_reg == '0)
            begin
                if (phase_reg == PH_W_HI && bi_reg == 4'd8)
                begin
                    ack_next = item.sda_in;
                end
                else if (phase_reg == PH_R_HI && bi_reg < 4'd8)
                begin
                    sh_next = {sh_reg[6:0], item.sda_in};
                end
            end
            dur     = is_setup(phase_reg) ? setup_len : half_len;
            tc_next = tc_reg + COUNT_WIDTH'(1);
            if (tc_next >= dur || tc_next == '0)
            begin
                case (phase_reg)
                    PH_ST_PRE:  begin go = 1'b1; target = PH_ST_HIGH; end
                    PH_ST_HIGH: begin go = 1'b1; target = PH_ST_HOLD; end
                    PH_ST_HOLD:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SP_PRE:  begin go = 1'b1; target = PH_SP_HIGH; end
                    PH_SP_HIGH: begin go = 1'b1; target = PH_SP_REL; end
                    PH_SP_REL:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_W_LOW:   begin go = 1'b1; target = PH_W_SET; end
                    PH_W_SET:   begin go = 1'b1; target = PH_W_HI; end
                    PH_R_LOW:   begin go = 1'b1; target = PH_R_SET; end
                    PH_R_SET:   begin go = 1'b1; target = PH_R_HI; end
                    PH_W_HI, PH_R_HI:
                    begin
                        if (phase_reg == PH_W_HI && bi_reg < 4'd8)
                        begin
                            sh_next = {sh_next[6:0], 1'b0};
                        end
                        bi_next = bi_reg + 4'd1;
                        if (bi_next >= 4'd9)
                        begin
                            if (phase_reg == PH_R_HI)
                            begin
                                rx_next = sh_next;
                            end
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            go     = 1'b1;
                            target = (phase_reg == PH_W_HI) ? PH_W_LOW : PH_R_LOW;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        if (go)
        begin
            bus = apply_phase('{phase: phase_next, scl: scl_next, sda: sda_next},
                              target, bi_next, sh_next, np_next);
            // zero setup skips straight to the following phase
            if (is_setup(target) && setup_len == '0)
            begin
                bus = apply_phase(bus, target + 4'd1, bi_next, sh_next, np_next);
            end
            phase_next = bus.phase;
            scl_next   = bus.scl;
            sda_next   = bus.sda;
            tc_next    = '0;
        end

        res_next.scl_level    = scl_next;
        res_next.sda_release  = sda_next;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.done_res     = done;
        res_next.rx_byte      = rx_next;
        res_next.ack_received = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_cfg_reg  <= HALF_PERIOD_RESET;
            setup_cfg_reg <= SETUP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HALF_PERIOD: half_cfg_reg  <= cfg.data;
                CFG_SETUP:       setup_cfg_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tc_reg        <= '0;
            bi_reg        <= '0;
            sh_reg        <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            np_reg        <= 1'b0;
            rx_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                tc_reg    <= tc_next;
                bi_reg    <= bi_next;
                sh_reg    <= sh_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                np_reg    <= np_next;
                rx_reg    <= rx_next;
            end
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.scl_level    = res_reg.scl_level;
    assign result.sda_release  = res_reg.sda_release;
    assign result.busy_res     = res_reg.busy_res;
    assign result.done_res     = res_reg.done_res;
    assign result.rx_byte      = res_reg.rx_byte;
    assign result.ack_received = res_reg.ack_received;

endmodule

// ===== src/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine.
// One tick request in, one result out; sustained rate one tick per clock while results are taken.
// A tick's result is registered: the tick is held in the two-entry queue, and the
// sequencer loads the result register when it takes the tick from the queue.
// Reset: bus released (SCL and SDA high), sequencer idle, received byte and
// ack cleared, half period 5 and setup 1.
module i2c_master_byte_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    i2cm_tick_if.sink     tick,
    i2cm_result_if.source result,
    i2cm_cfg_if.sink      cfg
);
    import i2cm_pkg::*;

    tick_item_t front_item, back_item;
    logic       front_valid, front_ready;
    logic       back_valid, back_ready;

    i2cm_front u_front (
        .tick       (tick),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    i2cm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .result     (result)
    );

endmodule

// ===== src/i2cm_checker.sv =====
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       scl_level,
    input logic       sda_release,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_received
);

    // a completed command always leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({scl_level, sda_release, busy_res, done_res, rx_byte, ack_received}))
        else $error("stalled result changed");

    // with the result side draining, the queue never backs up
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(res_ready) |-> tick_ready)
        else $error("tick request refused while results drain");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_ready   (tick.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .scl_level    (result.scl_level),
    .sda_release  (result.sda_release),
    .busy_res     (result.busy_res),
    .done_res     (result.done_res),
    .rx_byte      (result.rx_byte),
    .ack_received (result.ack_received)
);

// ===== tb/i2cm_bus_checker.sv =====
// Bus checker: follows ticks and register writes, predicts each result and compares it.
module i2cm_bus_checker
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_tick_if        tick,
    i2cm_result_if      result,
    i2cm_cfg_if         cfg,
    input  logic        run_over,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        BUS_IDLE,
        START_SETUP,
        START_HIGH,
        START_HOLD,
        STOP_SETUP,
        STOP_HIGH,
        STOP_RELEASE,
        WR_LOW,
        WR_SETUP,
        WR_HIGH,
        RD_LOW,
        RD_SETUP,
        RD_HIGH
    } bus_phase_e;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    logic [CFG_W-1:0]       half_cfg;
    logic [CFG_W-1:0]       setup_cfg;
    bus_phase_e             phase_q;
    logic [COUNT_WIDTH-1:0] ticks_q;
    logic [3:0]             bit_no;
    logic [7:0]             shift_q;
    logic                   scl_q;
    logic                   sda_q;
    logic                   ack_q;
    logic                   nack_q;
    logic [7:0]             rx_q;

    result_t     bus_levels_q[$];
    int unsigned errs;
    bit          closed;

    assign fail_count = errs;

    function automatic longint unsigned half_ticks();
        longint unsigned h;
        h = (half_cfg == '0) ? 1 : half_cfg;
        return (h > COUNT_MAX) ? COUNT_MAX : h;
    endfunction

    function automatic longint unsigned setup_ticks();
        longint unsigned s;
        s = setup_cfg;
        return (s > COUNT_MAX) ? COUNT_MAX : s;
    endfunction

    function automatic bit is_setup(bus_phase_e p);
        return p == START_SETUP || p == STOP_SETUP || p == WR_SETUP || p == RD_SETUP;
    endfunction

    // A phase shows its levels on the tick it is entered
    task automatic set_phase(bus_phase_e p);
        phase_q = p;
        ticks_q = '0;
        case (p)
            START_SETUP:  begin scl_q = 1'b0; sda_q = 1'b1; end
            START_HIGH:   begin scl_q = 1'b1; sda_q = 1'b1; end
            START_HOLD:   sda_q = 1'b0;
            STOP_SETUP:   begin scl_q = 1'b0; sda_q = 1'b0; end
            STOP_HIGH:    scl_q = 1'b1;
            STOP_RELEASE: sda_q = 1'b1;
            WR_LOW:       scl_q = 1'b0;
            WR_SETUP:     sda_q = (bit_no < 8) ? shift_q[7] : 1'b1;
            WR_HIGH:      scl_q = 1'b1;
            RD_LOW:       scl_q = 1'b0;
            RD_SETUP:     sda_q = (bit_no < 8) ? 1'b1 : nack_q;
            RD_HIGH:      scl_q = 1'b1;
            default:      ;
        endcase
    endtask

    // zero setup skips straight to the high phase
    task automatic enter_phase(bus_phase_e p);
        set_phase(p);
        if (is_setup(p) && setup_ticks() == 0)
            set_phase(bus_phase_e'(p + 1));
    endtask

    task automatic end_phase(output logic fin);
        fin = 1'b0;
        case (phase_q)
            START_SETUP:  enter_phase(START_HIGH);
            START_HIGH:   enter_phase(START_HOLD);
            START_HOLD:   begin scl_q = 1'b0; phase_q = BUS_IDLE; fin = 1'b1; end
            STOP_SETUP:   enter_phase(STOP_HIGH);
            STOP_HIGH:    enter_phase(STOP_RELEASE);
            STOP_RELEASE: begin phase_q = BUS_IDLE; fin = 1'b1; end
            WR_LOW:       enter_phase(WR_SETUP);
            WR_SETUP:     enter_phase(WR_HIGH);
            RD_LOW:       enter_phase(RD_SETUP);
            RD_SETUP:     enter_phase(RD_HIGH);
            WR_HIGH, RD_HIGH:
            begin
                if (phase_q == WR_HIGH && bit_no < 8)
                    shift_q = shift_q << 1;
                bit_no = bit_no + 1'b1;
                if (bit_no >= 9)
                begin
                    if (phase_q == RD_HIGH)
                        rx_q = shift_q;
                    scl_q   = 1'b0;
                    phase_q = BUS_IDLE;
                    fin     = 1'b1;
                end
                else
                begin
                    enter_phase(phase_q == WR_HIGH ? WR_LOW : RD_LOW);
                end
            end
            default:      phase_q = BUS_IDLE;
        endcase
    endtask

    task automatic predict_tick(input logic [2:0] code, input logic [7:0] data,
                                input logic nack, input logic sda, output result_t r);
        logic            fin;
        longint unsigned dur;
        fin = 1'b0;
        if (phase_q == BUS_IDLE)
        begin
            case (code)
                CMD_START: enter_phase(START_SETUP);
                CMD_STOP:  enter_phase(STOP_SETUP);
                CMD_WRITE:
                begin
                    shift_q = data;
                    bit_no  = '0;
                    enter_phase(WR_LOW);
                end
                CMD_READ:
                begin
                    shift_q = '0;
                    bit_no  = '0;
                    nack_q  = nack;
                    enter_phase(RD_LOW);
                end
                default:   ;
            endcase
        end
        else
        begin
            // SDA is sampled on the first tick of a high phase
            if (ticks_q == '0)
            begin
                if (phase_q == WR_HIGH && bit_no == 8)
                    ack_q = sda;
                else if (phase_q == RD_HIGH && bit_no < 8)
                    shift_q = {shift_q[6:0], sda};
            end
            dur     = is_setup(phase_q) ? setup_ticks() : half_ticks();
            ticks_q = ticks_q + 1'b1;
            if (ticks_q >= dur || ticks_q == '0)
                end_phase(fin);
        end
        r.scl_level    = scl_q;
        r.sda_release  = sda_q;
        r.busy_res     = (phase_q != BUS_IDLE);
        r.done_res     = fin;
        r.rx_byte      = rx_q;
        r.ack_received = ack_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            half_cfg  = HALF_PERIOD_RESET;
            setup_cfg = SETUP_RESET;
            phase_q   = BUS_IDLE;
            ticks_q   = '0;
            bit_no    = '0;
            shift_q   = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            ack_q     = 1'b0;
            nack_q    = 1'b0;
            rx_q      = '0;
            bus_levels_q.delete();
            errs      = 0;
            closed    = 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_HALF_PERIOD: half_cfg = cfg.data;
                    CFG_SETUP:       setup_cfg = cfg.data;
                    default:         ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (bus_levels_q.size() == 0)
                begin
                    $error("result arrived with no tick request outstanding");
                    errs++;
                end
                else
                begin
                    want = bus_levels_q.pop_front();
                    check_field("scl_level", want.scl_level, result.scl_level);
                    check_field("sda_release", want.sda_release, result.sda_release);
                    check_field("busy_res", want.busy_res, result.busy_res);
                    check_field("done_res", want.done_res, result.done_res);
                    check_field("rx_byte", want.rx_byte, result.rx_byte);
                    check_field("ack_received", want.ack_received, result.ack_received);
                end
            end
            if (tick.valid && tick.ready)
            begin
                predict_tick(tick.cmd, tick.tx_byte, tick.nack_after_read, tick.sda_in, want);
                bus_levels_q.push_back(want);
            end
            if (run_over && !closed)
            begin
                closed = 1'b1;
                if (bus_levels_q.size() != 0)
                begin
                    $error("%0d results never arrived", bus_levels_q.size());
                    errs += bus_levels_q.size();
                end
            end
        end
    end

endmodule

// ===== tb/i2c_master_byte_engine_top_test.sv =====
// Top of the I2C master byte engine testbench: clock, reset, stimulus and verdict.
module i2c_master_byte_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    typedef enum int unsigned {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } sda_drive_e;

    localparam logic [2:0]  CMD_CODE_LAST  = 3'd7;
    localparam int unsigned IDLE_PCT       = 26;
    localparam int unsigned CMDS_PER_PHASE = 12;
    // upper bound on the run; the run ends as a fail if it is reached
    localparam int unsigned CYCLE_LIMIT    = 40_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        run_over = 1'b0;
    logic        last_busy = 1'b0;
    bit          calm = 1'b0;
    bit          noisy = 1'b0;
    sda_drive_e  sda_mode = SDA_RANDOM;
    int unsigned sent = 0;
    int unsigned results_seen = 0;
    int unsigned dones = 0;
    int unsigned commands = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count;

    i2cm_tick_if   tick_ch ();
    i2cm_result_if res_ch ();
    i2cm_cfg_if    cfg_ch ();

    i2c_master_byte_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    i2cm_bus_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .run_over   (run_over),
        .fail_count (fail_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            results_seen <= results_seen + 1;
            dones        <= dones + res_ch.done_res;
            last_busy    <= res_ch.busy_res;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("i2c_master_byte_engine_top regression: fail");
            $finish;
        end
    end

    function automatic logic sda_bit();
        case (sda_mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    // mostly empty ticks; stray codes, and real commands only when allowed
    function automatic logic [2:0] filler_code(input bit allow_cmds);
        if (allow_cmds && $urandom_range(19) == 0)
            return 3'($urandom_range(CMD_READ, CMD_START));
        if ($urandom_range(9) == 0)
            return 3'($urandom_range(CMD_CODE_LAST, CMD_READ + 1));
        return CMD_NONE;
    endfunction

    task automatic send_tick(input logic [2:0] code, input logic [7:0] data, input logic nack);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.cmd             <= code;
        tick_ch.tx_byte         <= data;
        tick_ch.nack_after_read <= nack;
        tick_ch.sda_in          <= sda_bit();
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        if (results_seen != sent)
        begin
            tick_ch.valid <= 1'b0;
            while (results_seen != sent)
                @(posedge clk);
        end
    endtask

    task automatic send_filler(input bit allow_cmds);
        send_tick(filler_code(allow_cmds), 8'($urandom), 1'($urandom));
    endtask

    // one command on a drained engine, then, for a real command, timing ticks until it reports done
    task automatic do_cmd(input logic [2:0] code, input logic [7:0] data, input logic nack);
        int unsigned d0;
        drain();
        d0 = dones;
        send_tick(code, data, nack);
        commands++;
        if (code >= CMD_START && code <= CMD_READ)
            while (dones == d0)
                send_filler(noisy);
    endtask

    task automatic settle_bus();
        drain();
        while (last_busy)
        begin
            while (last_busy)
                send_filler(1'b0);
            drain();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] setup);
        settle_bus();
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_SETUP, setup);
    endtask

    task automatic random_transfer();
        int unsigned n;
        if ($urandom_range(3) == 0)
            sda_mode = sda_drive_e'($urandom_range(1));
        else
            sda_mode = SDA_RANDOM;
        if ($urandom_range(4) == 0)
        begin
            // lone command or stray code, whatever the bus state
            do_cmd(3'($urandom_range(CMD_CODE_LAST)), 8'($urandom), 1'($urandom));
        end
        else
        begin
            do_cmd(CMD_START, 8'($urandom), 1'($urandom));
            do_cmd(CMD_WRITE, 8'($urandom), 1'($urandom));
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(1))
                    do_cmd(CMD_WRITE, 8'($urandom), 1'($urandom));
                else
                    do_cmd(CMD_READ, 8'($urandom), (i == n - 1) ? 1'b1 : 1'($urandom));
            end
            if ($urandom_range(3) == 0)
            begin
                do_cmd(CMD_START, 8'($urandom), 1'($urandom));
                do_cmd(CMD_READ, 8'($urandom), 1'b1);
            end
            do_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] setup);
        int unsigned first;
        set_timing(half, setup);
        first = commands;
        noisy = 1'b1;
        while (commands - first < CMDS_PER_PHASE)
            random_transfer();
        noisy = 1'b0;
    endtask

    initial
    begin
        int unsigned d0;
        rst_n                   = 1'b0;
        tick_ch.valid           = 1'b0;
        tick_ch.cmd             = CMD_NONE;
        tick_ch.tx_byte         = '0;
        tick_ch.nack_after_read = 1'b0;
        tick_ch.sda_in          = 1'b1;
        res_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_HALF_PERIOD;
        cfg_ch.data             = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset timing
        sda_mode = SDA_LOW;
        do_cmd(CMD_START, 8'h00, 1'b0);
        do_cmd(CMD_WRITE, 8'hA5, 1'b0);
        sda_mode = SDA_RANDOM;
        do_cmd(CMD_READ, 8'h00, 1'b1);
        do_cmd(CMD_STOP, 8'h00, 1'b0);
        for (int c = CMD_READ + 1; c <= CMD_CODE_LAST; c++)
            do_cmd(3'(c), 8'hFF, 1'b1);
        // commands arriving while a start is running are dropped
        drain();
        d0 = dones;
        send_tick(CMD_START, 8'h00, 1'b0);
        send_tick(CMD_STOP, 8'hFF, 1'b1);
        send_tick(CMD_WRITE, 8'h3C, 1'b0);
        send_tick(CMD_READ, 8'hC3, 1'b1);
        while (dones == d0)
            send_filler(1'b0);

        random_phase(16'd1, 16'd0);
        calm = 1'b1;
        random_phase(16'd0, 16'd0);
        calm = 1'b0;
        random_phase(16'd1, 16'd2);

        settle_bus();
        repeat (8) @(posedge clk);
        run_over <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d tick requests carrying %0d commands: directed start, write, read,",
                 sent, commands);
        $display("stop and stray codes, then random transfers at half periods 0 and 1.");
        if (fail_count == 0)
            $display("i2c_master_byte_engine_top regression: pass");
        else
            $display("i2c_master_byte_engine_top regression: fail");
        $finish;
    end

endmodule
